// ----- hdl/ckspb_pkg.sv -----
// ----------------------------------------------------------------------------
// ckspb_pkg
// Shared widths, register indexes, setup states and the geometry bundle of
// the color-keyed sprite part blit.
// ----------------------------------------------------------------------------
package ckspb_pkg;

    localparam int POS_W      = 12;   // dest_x, dest_y
    localparam int DIM_W      = 13;   // stride, sheet width and height
    localparam int PART_W     = 8;    // part count and select
    localparam int ADDR_W     = 24;   // source index and frame buffer address
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_CNT_W  = 4;    // counts the quotient bits

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_X        = 3'd0,
        CFG_DEST_Y        = 3'd1,
        CFG_DEST_STRIDE   = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4,
        CFG_PART_COUNT    = 3'd5,
        CFG_PART_SELECT   = 3'd6,
        CFG_STACKED_BELOW = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        GEO_INIT,
        GEO_DIV,
        GEO_MUL1,
        GEO_MUL2,
        GEO_LOAD,
        GEO_READY
    } t_geo_state;

    typedef struct packed {
        logic              ready;
        logic              stacked;
        logic [DIM_W-1:0]  part_w;
        logic [DIM_W-1:0]  part_h;
        logic [DIM_W-1:0]  row_step;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] dest_base;
        logic [POS_W-1:0]  dest_x;
        logic [DIM_W-1:0]  dest_stride;
    } t_geo;

endpackage

// ----- hdl/ckspb_geom.sv -----
// ----------------------------------------------------------------------------
// ckspb_geom
// Configuration registers and the setup sequencer that derives the part
// geometry: a bit-serial divide, then the start index and row base products.
// ----------------------------------------------------------------------------
module ckspb_geom #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ckspb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckspb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ckspb_pkg::t_geo                  o_geo
);

    localparam int DIM_W  = ckspb_pkg::DIM_W;
    localparam int POS_W  = ckspb_pkg::POS_W;
    localparam int PART_W = ckspb_pkg::PART_W;
    localparam int ADDR_W = ckspb_pkg::ADDR_W;
    localparam logic [DIM_W-1:0] SAT_DIM = DIM_W'(MAX_DIM);
    localparam logic [ckspb_pkg::DIV_CNT_W-1:0] DIV_LAST = ckspb_pkg::DIV_CNT_W'(DIM_W - 1);

    logic [POS_W-1:0]  r_dest_x, r_dest_y;
    logic [DIM_W-1:0]  r_dest_stride, r_image_width, r_image_height;
    logic [PART_W-1:0] r_part_count, r_part_select;
    logic              r_stacked;

    ckspb_pkg::t_geo_state r_state, n_state;
    logic [ckspb_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [DIM_W-1:0]  r_dvd, n_dvd;
    logic [PART_W-1:0] r_rem, n_rem;
    logic [DIM_W-1:0]  r_part_w, n_part_w, r_part_h, n_part_h;
    logic [ADDR_W-1:0] r_prod, n_prod, r_start, n_start, r_base, n_base;

    logic [DIM_W-1:0]  sat_w, sat_h;
    logic [PART_W-1:0] parts;
    logic [PART_W:0]   trial;
    logic              q_bit;

    // saturated sheet size, zero part count read as one
    assign sat_w = (32'(r_image_width) > MAX_DIM) ? SAT_DIM : r_image_width;
    assign sat_h = (32'(r_image_height) > MAX_DIM) ? SAT_DIM : r_image_height;
    assign parts = (r_part_count == '0) ? PART_W'(1) : r_part_count;

    // one restoring divide step
    assign trial = {r_rem, r_dvd[DIM_W-1]};
    assign q_bit = (trial >= {1'b0, parts});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x       <= '0;
            r_dest_y       <= '0;
            r_dest_stride  <= DIM_W'(1);
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
            r_part_count   <= PART_W'(1);
            r_part_select  <= '0;
            r_stacked      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (ckspb_pkg::t_cfg_reg'(i_cfg_index))
                ckspb_pkg::CFG_DEST_X:        r_dest_x       <= i_cfg_data[POS_W-1:0];
                ckspb_pkg::CFG_DEST_Y:        r_dest_y       <= i_cfg_data[POS_W-1:0];
                ckspb_pkg::CFG_DEST_STRIDE:   r_dest_stride  <= i_cfg_data[DIM_W-1:0];
                ckspb_pkg::CFG_IMAGE_WIDTH:   r_image_width  <= i_cfg_data[DIM_W-1:0];
                ckspb_pkg::CFG_IMAGE_HEIGHT:  r_image_height <= i_cfg_data[DIM_W-1:0];
                ckspb_pkg::CFG_PART_COUNT:    r_part_count   <= i_cfg_data[PART_W-1:0];
                ckspb_pkg::CFG_PART_SELECT:   r_part_select  <= i_cfg_data[PART_W-1:0];
                ckspb_pkg::CFG_STACKED_BELOW: r_stacked      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckspb_pkg::GEO_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_part_w <= n_part_w;
        r_part_h <= n_part_h;
        r_prod   <= n_prod;
        r_start  <= n_start;
        r_base   <= n_base;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_part_w = r_part_w;
        n_part_h = r_part_h;
        n_prod   = r_prod;
        n_start  = r_start;
        n_base   = r_base;
        unique case (r_state)
            ckspb_pkg::GEO_INIT: begin
                n_dvd   = r_stacked ? sat_h : sat_w;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ckspb_pkg::GEO_DIV;
            end
            ckspb_pkg::GEO_DIV: begin
                // quotient bits shift in where dividend bits leave
                n_rem   = q_bit ? PART_W'(trial - {1'b0, parts}) : trial[PART_W-1:0];
                n_dvd   = {r_dvd[DIM_W-2:0], q_bit};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ckspb_pkg::GEO_MUL1;
                end
            end
            ckspb_pkg::GEO_MUL1: begin
                n_part_w = r_stacked ? sat_w : r_dvd;
                n_part_h = r_stacked ? r_dvd : sat_h;
                n_prod   = r_stacked ? ADDR_W'(sat_w * r_dvd) : ADDR_W'(r_dvd);
                n_base   = ADDR_W'(r_dest_y * r_dest_stride);
                n_state  = ckspb_pkg::GEO_MUL2;
            end
            ckspb_pkg::GEO_MUL2: begin
                n_start = ADDR_W'(r_prod * r_part_select);
                n_state = ckspb_pkg::GEO_LOAD;
            end
            ckspb_pkg::GEO_LOAD: begin
                n_state = ckspb_pkg::GEO_READY;
            end
            ckspb_pkg::GEO_READY: begin
                n_state = ckspb_pkg::GEO_READY;
            end
            default: begin
                n_state = ckspb_pkg::GEO_INIT;
            end
        endcase
        // any register write restarts the setup
        if (i_cfg_we) begin
            n_state = ckspb_pkg::GEO_INIT;
        end
    end

    always_comb begin
        o_geo.ready       = (r_state == ckspb_pkg::GEO_READY);
        o_geo.stacked     = r_stacked;
        o_geo.part_w      = r_part_w;
        o_geo.part_h      = r_part_h;
        o_geo.row_step    = sat_w;
        o_geo.start       = r_start;
        o_geo.dest_base   = r_base;
        o_geo.dest_x      = r_dest_x;
        o_geo.dest_stride = r_dest_stride;
    end

    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == ckspb_pkg::GEO_INIT))
        else $error("setup did not restart after register write");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ckspb_pkg::GEO_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divide step count out of range");

    a_side_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_geo.ready && !r_stacked) |-> (r_part_h == sat_h))
        else $error("side by side part height differs from sheet height");

endmodule

// ----- hdl/ckspb_walk.sv -----
// ----------------------------------------------------------------------------
// ckspb_walk
// Raster walk over the selected part: counters, source cursor and row base,
// with one result register holding each pixel transfer.
// ----------------------------------------------------------------------------
module ckspb_walk #(
    parameter logic [ckspb_pkg::PIX_W-1:0] TRANSPARENT_KEY = 32'h00FF00FF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ckspb_pkg::t_geo               i_geo,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ckspb_pkg::PIX_W-1:0]   i_src_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ckspb_pkg::ADDR_W-1:0]  o_src_index,
    output logic [ckspb_pkg::ADDR_W-1:0]  o_dest_address,
    output logic [ckspb_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                          o_write_enable,
    output logic                          o_last_pixel
);

    localparam int DIM_W  = ckspb_pkg::DIM_W;
    localparam int ADDR_W = ckspb_pkg::ADDR_W;
    localparam int PIX_W  = ckspb_pkg::PIX_W;

    logic [DIM_W-1:0]  r_col, n_col, r_row, n_row;
    logic [ADDR_W-1:0] r_cursor, n_cursor, r_row_start, n_row_start;
    logic [ADDR_W-1:0] r_row_base, n_row_base;

    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_src_index, n_src_index, r_dest_addr, n_dest_addr;
    logic [PIX_W-1:0]  r_pixel, n_pixel;
    logic              r_we, n_we, r_last, n_last;

    logic acc, empty, fire, col_last, row_last, last;

    assign o_in_stall = !i_geo.ready || (r_out_valid && i_out_stall);
    assign acc        = i_in_valid && !o_in_stall;
    // an empty part swallows the transfer and gives nothing
    assign empty      = (i_geo.part_w == '0) || (i_geo.part_h == '0);
    assign fire       = acc && !empty;
    assign col_last   = (r_col == i_geo.part_w - 1'b1);
    assign row_last   = (r_row == i_geo.part_h - 1'b1);
    assign last       = col_last && row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_row       <= n_row;
        r_cursor    <= n_cursor;
        r_row_start <= n_row_start;
        r_row_base  <= n_row_base;
        r_src_index <= n_src_index;
        r_dest_addr <= n_dest_addr;
        r_pixel     <= n_pixel;
        r_we        <= n_we;
        r_last      <= n_last;
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_cursor    = r_cursor;
        n_row_start = r_row_start;
        n_row_base  = r_row_base;
        priority if (!i_geo.ready || (fire && last)) begin
            // first pixel of the part
            n_col       = '0;
            n_row       = '0;
            n_cursor    = i_geo.start;
            n_row_start = i_geo.start;
            n_row_base  = i_geo.dest_base;
        end else if (fire && col_last) begin
            n_col      = '0;
            n_row      = r_row + 1'b1;
            n_row_base = r_row_base + ADDR_W'(i_geo.dest_stride);
            if (i_geo.stacked) begin
                n_row_start = r_cursor + 1'b1;
                n_cursor    = r_cursor + 1'b1;
            end else begin
                n_row_start = r_row_start + ADDR_W'(i_geo.row_step);
                n_cursor    = r_row_start + ADDR_W'(i_geo.row_step);
            end
        end else if (fire) begin
            n_col    = r_col + 1'b1;
            n_cursor = r_cursor + 1'b1;
        end else begin
        end
    end

    always_comb begin
        n_src_index = r_src_index;
        n_dest_addr = r_dest_addr;
        n_pixel     = r_pixel;
        n_we        = r_we;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        if (fire) begin
            n_out_valid = 1'b1;
            n_src_index = r_cursor;
            n_dest_addr = r_row_base + ADDR_W'(i_geo.dest_x) + ADDR_W'(r_col);
            n_pixel     = i_src_pixel;
            n_we        = (i_src_pixel != TRANSPARENT_KEY);
            n_last      = last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_src_index    = r_src_index;
    assign o_dest_address = r_dest_addr;
    assign o_out_pixel    = r_pixel;
    assign o_write_enable = r_we;
    assign o_last_pixel   = r_last;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_geo.ready && !empty) |-> (r_col < i_geo.part_w && r_row < i_geo.part_h))
        else $error("walk position outside the part");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (r_col == '0 && r_row == '0 && r_cursor == i_geo.start))
        else $error("walk did not restart after the last pixel");

    a_ready_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_geo.ready) |-> (r_col == '0 && r_row == '0
                                && r_row_base == i_geo.dest_base))
        else $error("walk not at the first pixel when setup finished");

endmodule

// ----- hdl/color_keyed_sprite_part_blit.sv -----
// A pixel transfer shows up on the result port in the cycle after it is taken.
// Throughput: one pixel per cycle; a stalled result register holds off the input.
// After reset and after every register write the geometry setup (load, 13 divide
// steps in a shared restoring divider, two multiply steps, load) runs with o_in_stall
// high throughout; the walk then restarts at the part's first pixel.
// Reset is synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
// color_keyed_sprite_part_blit
// Copies one part of a sprite sheet into a frame buffer, giving source index,
// destination address and a color-keyed write enable for every pixel.
// ----------------------------------------------------------------------------
module color_keyed_sprite_part_blit #(
    parameter logic [31:0] TRANSPARENT_KEY = 32'd16711935,
    parameter int          MAX_DIM         = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ckspb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckspb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ckspb_pkg::PIX_W-1:0]      i_src_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ckspb_pkg::ADDR_W-1:0]     o_src_index,
    output logic [ckspb_pkg::ADDR_W-1:0]     o_dest_address,
    output logic [ckspb_pkg::PIX_W-1:0]      o_out_pixel,
    output logic                             o_write_enable,
    output logic                             o_last_pixel
);

    ckspb_pkg::t_geo geo;

    ckspb_geom #(
        .MAX_DIM (MAX_DIM)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geo       (geo)
    );

    ckspb_walk #(
        .TRANSPARENT_KEY (TRANSPARENT_KEY)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geo          (geo),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_pixel    (i_src_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_src_index    (o_src_index),
        .o_dest_address (o_dest_address),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

// ----- test/color_keyed_sprite_part_blit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_keyed_sprite_part_blit_test
// Drives pixels through the sprite part blit over many sheet geometries and
// checks every frame buffer write (source index, address, pixel, key enable,
// end-of-part flag) against a cycle-free model of the raster walk.
// ----------------------------------------------------------------------------
module color_keyed_sprite_part_blit_test;

    localparam int POS_W      = ckspb_pkg::POS_W;
    localparam int DIM_W      = ckspb_pkg::DIM_W;
    localparam int PART_W     = ckspb_pkg::PART_W;
    localparam int ADDR_W     = ckspb_pkg::ADDR_W;
    localparam int PIX_W      = ckspb_pkg::PIX_W;
    localparam int CFG_IDX_W  = ckspb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ckspb_pkg::CFG_DATA_W;

    localparam logic [PIX_W-1:0] KEY_COLOR     = 32'h00FF00FF;
    localparam int unsigned      SHEET_MAX_DIM = 4096;
    localparam int               ITEM_TARGET   = 1900;
    localparam int               CYCLE_LIMIT   = 500000;
    localparam int               HOLD_CYCLES   = 300;
    localparam int               MAX_REPORTS   = 40;

    typedef struct {
        logic [ADDR_W-1:0] src_index;
        logic [ADDR_W-1:0] dest_address;
        logic [PIX_W-1:0]  pixel;
        logic              write_enable;
        logic              last_pixel;
    } t_fb_write;

    class blit_scoreboard;
        bit [POS_W-1:0]   dest_x, dest_y;
        bit [DIM_W-1:0]   dest_stride, image_width, image_height;
        bit [PART_W-1:0]  part_count, part_select;
        bit               stacked_below;

        int unsigned      part_w, part_h, row_step, col, row;
        bit [ADDR_W-1:0]  part_start, cursor, row_start, dest_base;

        t_fb_write        pending_writes[$];
        int               mismatches, results_seen, parts_done, keyed_pixels;

        function void reset_model();
            dest_x        = '0;
            dest_y        = '0;
            dest_stride   = DIM_W'(1);
            image_width   = DIM_W'(1);
            image_height  = DIM_W'(1);
            part_count    = PART_W'(1);
            part_select   = '0;
            stacked_below = 1'b1;
            restart_walk();
        endfunction

        // part geometry and walk position, redone on every register write
        function void restart_walk();
            longint unsigned w, h, p, span, base;
            w = (image_width > SHEET_MAX_DIM) ? SHEET_MAX_DIM : image_width;
            h = (image_height > SHEET_MAX_DIM) ? SHEET_MAX_DIM : image_height;
            p = (part_count == 0) ? 1 : part_count;
            if (stacked_below) begin
                part_w = 32'(w);
                part_h = 32'(h / p);
                span   = w * part_h * part_select;
            end else begin
                part_w = 32'(w / p);
                part_h = 32'(h);
                span   = longint'(part_w) * part_select;
            end
            base       = longint'(dest_y) * dest_stride;
            part_start = span[ADDR_W-1:0];
            row_step   = 32'(w);
            col        = 0;
            row        = 0;
            cursor     = part_start;
            row_start  = part_start;
            dest_base  = base[ADDR_W-1:0];
        endfunction

        function void write_reg(ckspb_pkg::t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
            case (r)
                ckspb_pkg::CFG_DEST_X:        dest_x        = v[POS_W-1:0];
                ckspb_pkg::CFG_DEST_Y:        dest_y        = v[POS_W-1:0];
                ckspb_pkg::CFG_DEST_STRIDE:   dest_stride   = v[DIM_W-1:0];
                ckspb_pkg::CFG_IMAGE_WIDTH:   image_width   = v[DIM_W-1:0];
                ckspb_pkg::CFG_IMAGE_HEIGHT:  image_height  = v[DIM_W-1:0];
                ckspb_pkg::CFG_PART_COUNT:    part_count    = v[PART_W-1:0];
                ckspb_pkg::CFG_PART_SELECT:   part_select   = v[PART_W-1:0];
                ckspb_pkg::CFG_STACKED_BELOW: stacked_below = v[0];
                default: ;
            endcase
            restart_walk();
        endfunction

        function bit part_empty();
            return part_w == 0 || part_h == 0;
        endfunction

        function int unsigned part_pixels();
            return part_w * part_h;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        // one pixel transfer in, at most one frame buffer write expected
        function void take_pixel(logic [PIX_W-1:0] px);
            t_fb_write e;
            bit        last;
            if (part_empty())
                return;
            last           = (col == part_w - 1) && (row == part_h - 1);
            e.src_index    = cursor;
            e.dest_address = ADDR_W'(dest_base + dest_x + col);
            e.pixel        = px;
            e.write_enable = (px != KEY_COLOR);
            e.last_pixel   = last;
            pending_writes.push_back(e);
            if (last) begin
                restart_walk();
                return;
            end
            col++;
            cursor = cursor + 1'b1;
            if (col == part_w) begin
                col = 0;
                row++;
                // side by side parts skip the rest of the sheet row
                if (stacked_below)
                    row_start = cursor;
                else
                    row_start = row_start + row_step[ADDR_W-1:0];
                cursor    = row_start;
                dest_base = dest_base + dest_stride;
            end
        endfunction

        function void flag(string what, logic [PIX_W-1:0] exp_v,
                           logic [PIX_W-1:0] act_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
        endfunction

        function void check_write(t_fb_write got);
            t_fb_write e;
            results_seen++;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected write, expected none, actual addr %h pixel %h",
                             $time, got.dest_address, got.pixel);
                return;
            end
            e = pending_writes.pop_front();
            if (e.last_pixel)
                parts_done++;
            if (!e.write_enable)
                keyed_pixels++;
            if (got.src_index !== e.src_index)
                flag("src_index", PIX_W'(e.src_index), PIX_W'(got.src_index));
            if (got.dest_address !== e.dest_address)
                flag("dest_address", PIX_W'(e.dest_address), PIX_W'(got.dest_address));
            if (got.pixel !== e.pixel)
                flag("out_pixel", e.pixel, got.pixel);
            if (got.write_enable !== e.write_enable)
                flag("write_enable", PIX_W'(e.write_enable), PIX_W'(got.write_enable));
            if (got.last_pixel !== e.last_pixel)
                flag("last_pixel", PIX_W'(e.last_pixel), PIX_W'(got.last_pixel));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_src_pixel;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ADDR_W-1:0]     o_src_index;
    logic [ADDR_W-1:0]     o_dest_address;
    logic [PIX_W-1:0]      o_out_pixel;
    logic                  o_write_enable;
    logic                  o_last_pixel;

    blit_scoreboard        sb;
    logic [CFG_DATA_W-1:0] setting [8];
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    bit                    hold_request = 1'b0;
    bit                    hold_done = 1'b0;
    int                    items_sent = 0;
    int                    phases = 0;
    int                    cycle_count = 0;

    color_keyed_sprite_part_blit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_pixel    (i_src_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_src_index    (o_src_index),
        .o_dest_address (o_dest_address),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable),
        .o_last_pixel   (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d writes still expected",
                     $time, CYCLE_LIMIT, sb.pending());
            $display("color_keyed_sprite_part_blit_test NOT OK");
            $finish;
        end
    end

    // both transfers are seen on the values from before the edge
    always @(posedge i_clk) begin
        t_fb_write got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.take_pixel(i_src_pixel);
            if (o_out_valid && !i_out_stall) begin
                got.src_index    = o_src_index;
                got.dest_address = o_dest_address;
                got.pixel        = o_out_pixel;
                got.write_enable = o_write_enable;
                got.last_pixel   = o_last_pixel;
                sb.check_write(got);
            end
        end
    end

    // frame buffer side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(15))
            0, 1:    return KEY_COLOR;
            2:       return KEY_COLOR ^ (32'd1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_cfg(int unsigned lo, int unsigned hi);
        return CFG_DATA_W'($urandom_range(lo, hi));
    endfunction

    // holds the write enable across back-to-back writes, caller lowers it
    task automatic write_reg(ckspb_pkg::t_cfg_reg r);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= setting[r];
        @(posedge i_clk);
        sb.write_reg(r, setting[r]);
    endtask

    task automatic write_all();
        ckspb_pkg::t_cfg_reg r;
        r = r.first();
        forever begin
            write_reg(r);
            if (r == r.last())
                break;
            r = r.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_src_pixel <= px;
        do @(posedge i_clk); while (o_in_stall);
        if (!sb.part_empty())
            items_sent++;
    endtask

    // an empty part takes pixels without a result, so allow a few cycles more
    task automatic drain();
        i_in_valid <= 1'b0;
        // step to the clock edge first so the last pixel transfer is already in the model
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        phases++;
    endtask

    task automatic pick_setting();
        int unsigned kind, parts;
        kind                                  = $urandom_range(9);
        setting[ckspb_pkg::CFG_DEST_X]        = rand_cfg(0, 8191);
        setting[ckspb_pkg::CFG_DEST_Y]        = rand_cfg(0, 8191);
        setting[ckspb_pkg::CFG_DEST_STRIDE]   = rand_cfg(0, 8191);
        setting[ckspb_pkg::CFG_STACKED_BELOW] = rand_cfg(0, 8191);
        if (kind <= 5) begin
            parts                                = $urandom_range(1, 4);
            setting[ckspb_pkg::CFG_IMAGE_WIDTH]  = rand_cfg(1, 12);
            setting[ckspb_pkg::CFG_IMAGE_HEIGHT] = rand_cfg(1, 12);
            setting[ckspb_pkg::CFG_PART_COUNT]   = CFG_DATA_W'(parts);
            setting[ckspb_pkg::CFG_PART_SELECT]  = ($urandom_range(7) == 0)
                                                 ? rand_cfg(0, 255)
                                                 : rand_cfg(0, parts - 1);
        end else if (kind == 6) begin
            // more parts than pixels along the split: nothing to draw
            setting[ckspb_pkg::CFG_IMAGE_WIDTH]  = rand_cfg(0, 6);
            setting[ckspb_pkg::CFG_IMAGE_HEIGHT] = rand_cfg(0, 6);
            setting[ckspb_pkg::CFG_PART_COUNT]   = rand_cfg(7, 255);
            setting[ckspb_pkg::CFG_PART_SELECT]  = rand_cfg(0, 255);
        end else begin
            setting[ckspb_pkg::CFG_IMAGE_WIDTH]  = rand_cfg(0, 8191);
            setting[ckspb_pkg::CFG_IMAGE_HEIGHT] = rand_cfg(0, 8191);
            setting[ckspb_pkg::CFG_PART_COUNT]   = rand_cfg(0, 8191);
            setting[ckspb_pkg::CFG_PART_SELECT]  = rand_cfg(0, 8191);
        end
    endtask

    initial begin
        ckspb_pkg::t_cfg_reg r;
        int unsigned         region, n;
        sb = new();
        sb.reset_model();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= ckspb_pkg::CFG_DEST_X;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_src_pixel <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: a single pixel part, every pixel ends it
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(KEY_COLOR);
        send_pixel(KEY_COLOR ^ 32'h1);
        drain();

        // side by side, second of two parts, rows skip the full sheet width
        setting[ckspb_pkg::CFG_DEST_X]        = 13'd5;
        setting[ckspb_pkg::CFG_DEST_Y]        = 13'd3;
        setting[ckspb_pkg::CFG_DEST_STRIDE]   = 13'd20;
        setting[ckspb_pkg::CFG_IMAGE_WIDTH]   = 13'd8;
        setting[ckspb_pkg::CFG_IMAGE_HEIGHT]  = 13'd2;
        setting[ckspb_pkg::CFG_PART_COUNT]    = 13'd2;
        setting[ckspb_pkg::CFG_PART_SELECT]   = 13'd1;
        setting[ckspb_pkg::CFG_STACKED_BELOW] = 13'd0;
        write_all();
        repeat (9) send_pixel(rand_pixel());
        drain();

        // oversized sheet, selection far past the last part, start index wraps
        setting[ckspb_pkg::CFG_DEST_X]        = 13'h1FFF;
        setting[ckspb_pkg::CFG_DEST_Y]        = 13'h1FFF;
        setting[ckspb_pkg::CFG_DEST_STRIDE]   = 13'h1FFF;
        setting[ckspb_pkg::CFG_IMAGE_WIDTH]   = 13'h1FFF;
        setting[ckspb_pkg::CFG_IMAGE_HEIGHT]  = 13'h1FFF;
        setting[ckspb_pkg::CFG_PART_COUNT]    = 13'd3;
        setting[ckspb_pkg::CFG_PART_SELECT]   = 13'd255;
        setting[ckspb_pkg::CFG_STACKED_BELOW] = 13'd1;
        write_all();
        repeat (3) send_pixel(rand_pixel());
        drain();

        // zero part count acts as one; address crosses the top of the frame buffer
        setting[ckspb_pkg::CFG_DEST_X]        = 13'd4095;
        setting[ckspb_pkg::CFG_DEST_Y]        = 13'd4095;
        setting[ckspb_pkg::CFG_DEST_STRIDE]   = 13'd4096;
        setting[ckspb_pkg::CFG_IMAGE_WIDTH]   = 13'd3;
        setting[ckspb_pkg::CFG_IMAGE_HEIGHT]  = 13'd2;
        setting[ckspb_pkg::CFG_PART_COUNT]    = 13'd0;
        setting[ckspb_pkg::CFG_PART_SELECT]   = 13'd0;
        write_all();
        repeat (3) send_pixel(rand_pixel());
        drain();

        // empty part: pixels are taken, nothing is written
        setting[ckspb_pkg::CFG_PART_COUNT] = 13'd5;
        write_all();
        repeat (2) send_pixel(rand_pixel());
        drain();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
                tx_idle_pct = 30;
                rx_idle_pct = 72;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(3) == 0) begin
                // one register rewritten: the walk restarts from the part's first pixel
                r          = ckspb_pkg::t_cfg_reg'($urandom_range(7));
                setting[r] = rand_cfg(0, 8191);
                write_reg(r);
                i_cfg_we <= 1'b0;
            end else begin
                pick_setting();
                write_all();
            end
            region = sb.part_pixels();
            if (region == 0)
                n = $urandom_range(1, 4);
            else if (region <= 40)
                n = region * $urandom_range(1, 3) + $urandom_range(3);
            else
                n = $urandom_range(10, 40);
            if (tx_idle_pct == 0 && !hold_done && region != 0) begin
                if (n < 40)
                    n = 40;
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            repeat (n) send_pixel(rand_pixel());
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d counted pixels over %0d setups, %0d writes checked",
                 items_sent, phases, sb.results_seen);
        $display("%0d parts completed, %0d keyed pixels, %0d mismatches, %0d writes left over",
                 sb.parts_done, sb.keyed_pixels, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("color_keyed_sprite_part_blit_test OK");
        else
            $display("color_keyed_sprite_part_blit_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ckspb_pkg.sv
hdl/ckspb_geom.sv
hdl/ckspb_walk.sv
hdl/color_keyed_sprite_part_blit.sv
test/color_keyed_sprite_part_blit_test.sv
